FILE: sv/assert_macros.svh
// assertion macros for the heap queue rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("heap queue assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("heap queue assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, cond, prop)

`define ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

FILE: sv/bmhq_pkg.sv
package bmhq_pkg;

    localparam int POS_W   = 17;
    localparam int SHIFT_W = 5;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] node;
    } entry_t;

    typedef enum logic {
        OP_PUSH,
        OP_POP
    } link_op_t;

    // token handed from one level to the next
    typedef struct packed {
        logic                 valid;
        link_op_t             op;
        logic [POS_W-1:0]     pos;
        logic [SHIFT_W-1:0]   shift;
        entry_t               item;
    } link_t;

    // write of a promoted entry into the level above
    typedef struct packed {
        logic             we;
        logic [POS_W-1:0] pos;
        entry_t           item;
    } up_t;

    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] pos;
    } tail_req_t;

    function automatic logic ranks_before(input entry_t a, input entry_t b);
        return (a.key < b.key) || ((a.key == b.key) && (a.node < b.node));
    endfunction

endpackage

FILE: sv/bmhq_level.sv
module bmhq_level #(
    parameter int QUEUE_DEPTH = 1024,
    parameter int LEVEL       = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [bmhq_pkg::POS_W-1:0]    fill,
    input  bmhq_pkg::tail_req_t           tail_req,
    input  bmhq_pkg::link_t               link_in,
    output bmhq_pkg::link_t               link_out,
    input  bmhq_pkg::up_t                 up_in,
    output bmhq_pkg::up_t                 up_out,
    output bmhq_pkg::entry_t              tail_entry,
    output logic                          done
);

    localparam int POS_W      = bmhq_pkg::POS_W;
    localparam int SHIFT_W    = bmhq_pkg::SHIFT_W;
    localparam int PW         = $clog2(QUEUE_DEPTH + 1);
    localparam int SW         = $clog2(PW);
    localparam int LEVEL_SIZE = 1 << LEVEL;
    localparam int ENTRIES    = (QUEUE_DEPTH - LEVEL_SIZE + 1 < LEVEL_SIZE) ?
                                (QUEUE_DEPTH - LEVEL_SIZE + 1) : LEVEL_SIZE;
    localparam int ROWS       = (ENTRIES + 1) / 2;
    localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROW_N      = 1 << ROW_W;
    localparam logic [PW-1:0] LEVEL_BIT = PW'(LEVEL_SIZE);

    function automatic logic [ROW_W-1:0] row_of(input logic [PW-1:0] p);
        logic [PW-1:0] offset;
        offset = (p & ~LEVEL_BIT) >> 1;
        return offset[ROW_W-1:0];
    endfunction

    bmhq_pkg::entry_t mem_even [ROW_N];
    bmhq_pkg::entry_t mem_odd  [ROW_N];

    logic                  act_reg;
    bmhq_pkg::link_op_t    op_reg;
    logic [PW-1:0]         pos_reg;
    logic [SW-1:0]         shift_reg;
    bmhq_pkg::entry_t      item_reg;
    bmhq_pkg::entry_t      rd_even_reg;
    bmhq_pkg::entry_t      rd_odd_reg;
    logic                  rd_slot_reg;

    logic [PW-1:0]         in_pos;
    logic [PW-1:0]         tq_pos;
    logic [PW-1:0]         fill_w;
    logic [PW-1:0]         push_p;
    logic                  rd_en;
    logic [ROW_W-1:0]      rd_row;
    logic                  rd_slot;

    logic [PW-1:0]         cur_p;
    bmhq_pkg::entry_t      slot_item;
    logic [PW:0]           lpos;
    logic [PW:0]           rpos;
    logic [PW:0]           fill_x;
    logic                  use_right;
    bmhq_pkg::entry_t      child;
    logic [PW-1:0]         cpos;
    logic                  win;
    logic                  has_grand;

    logic                  own_we;
    logic [PW-1:0]         own_pos;
    bmhq_pkg::entry_t      own_item;
    logic                  wr_en;
    logic [PW-1:0]         wr_pos;
    bmhq_pkg::entry_t      wr_item;

    assign in_pos = link_in.pos[PW-1:0];
    assign tq_pos = tail_req.pos[PW-1:0];
    assign fill_w = fill[PW-1:0];
    assign push_p = in_pos >> link_in.shift[SW-1:0];

    // read port: incoming token or tail fetch
    always_comb
    begin
        rd_en   = 1'b0;
        rd_row  = '0;
        rd_slot = 1'b0;
        if (link_in.valid)
        begin
            rd_en = 1'b1;
            if (link_in.op == bmhq_pkg::OP_PUSH)
            begin
                rd_row  = row_of(push_p);
                rd_slot = push_p[0];
            end
            else
            begin
                rd_row = row_of({in_pos[PW-2:0], 1'b0});
            end
        end
        else if (tail_req.en && ((tq_pos >> LEVEL) == PW'(1)))
        begin
            rd_en   = 1'b1;
            rd_row  = row_of(tq_pos);
            rd_slot = tq_pos[0];
        end
    end

    assign cur_p     = pos_reg >> shift_reg;
    assign slot_item = rd_slot_reg ? rd_odd_reg : rd_even_reg;
    assign lpos      = {pos_reg, 1'b0};
    assign rpos      = {pos_reg, 1'b1};
    assign fill_x    = {1'b0, fill_w};
    assign use_right = (rpos <= fill_x) && bmhq_pkg::ranks_before(rd_odd_reg, rd_even_reg);
    assign child     = use_right ? rd_odd_reg : rd_even_reg;
    assign cpos      = use_right ? rpos[PW-1:0] : lpos[PW-1:0];
    assign win       = bmhq_pkg::ranks_before(child, item_reg);
    assign has_grand = ({cpos, 1'b0} <= fill_x);

    always_comb
    begin
        own_we   = 1'b0;
        own_pos  = cur_p;
        own_item = item_reg;
        link_out = '0;
        up_out   = '0;
        done     = 1'b0;
        if (act_reg)
        begin
            case (op_reg)
                bmhq_pkg::OP_PUSH:
                begin
                    if (shift_reg == '0)
                    begin
                        own_we = 1'b1;
                        done   = 1'b1;
                    end
                    else
                    begin
                        link_out.valid = 1'b1;
                        link_out.op    = bmhq_pkg::OP_PUSH;
                        link_out.pos   = POS_W'(pos_reg);
                        link_out.shift = SHIFT_W'(shift_reg - 1'b1);
                        if (bmhq_pkg::ranks_before(item_reg, slot_item))
                        begin
                            own_we        = 1'b1;
                            link_out.item = slot_item;
                        end
                        else
                        begin
                            link_out.item = item_reg;
                        end
                    end
                end
                bmhq_pkg::OP_POP:
                begin
                    up_out.we  = 1'b1;
                    up_out.pos = POS_W'(pos_reg);
                    if (win)
                    begin
                        up_out.item = child;
                        if (has_grand)
                        begin
                            link_out.valid = 1'b1;
                            link_out.op    = bmhq_pkg::OP_POP;
                            link_out.pos   = POS_W'(cpos);
                            link_out.item  = item_reg;
                        end
                        else
                        begin
                            own_we  = 1'b1;
                            own_pos = cpos;
                            done    = 1'b1;
                        end
                    end
                    else
                    begin
                        up_out.item = item_reg;
                        done        = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign wr_en   = own_we | up_in.we;
    assign wr_pos  = own_we ? own_pos : up_in.pos[PW-1:0];
    assign wr_item = own_we ? own_item : up_in.item;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (wr_pos[0])
            begin
                mem_odd[row_of(wr_pos)] <= wr_item;
            end
            else
            begin
                mem_even[row_of(wr_pos)] <= wr_item;
            end
        end
        if (rd_en)
        begin
            rd_even_reg <= mem_even[rd_row];
            rd_odd_reg  <= mem_odd[rd_row];
            rd_slot_reg <= rd_slot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_in.valid)
        begin
            op_reg    <= link_in.op;
            pos_reg   <= in_pos;
            shift_reg <= link_in.shift[SW-1:0];
            item_reg  <= link_in.item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
        end
        else
        begin
            act_reg <= link_in.valid;
        end
    end

    assign tail_entry = rd_slot_reg ? rd_odd_reg : rd_even_reg;

endmodule

FILE: sv/binary_min_heap_queue.sv
// channel   direction  transfer when             payload
// in        input      in_valid && !in_stall     command, push_key, push_node
// out       output     out_valid && !out_stall   status, popped_*, top_*, entry_count,
//                                                peak_count
// cfg       input      cfg_write_en              cfg_write_data (capacity_limit)
//
// one item at a time; clear, no-op, full push, empty pop and a pop to empty go straight to the result
// a push walks the levels down to the new entry's level d (up to 10 at depth 1024)
// a pop reads the tail entry, then the sift-down walks one heap level cell per cycle
// reset empties the queue at once and sets capacity_limit to 1024, no clearing pass
// in_stall is high while an item is at work or its result waits for the out register
`include "assert_macros.svh"

module binary_min_heap_queue #(
    parameter int QUEUE_DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [31:0] push_key,
    input  logic [31:0] push_node,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] popped_key,
    output logic [31:0] popped_node,
    output logic        top_valid,
    output logic [31:0] top_key,
    output logic [31:0] top_node,
    output logic [10:0] entry_count,
    output logic [10:0] peak_count,
    input  logic        cfg_write_en,
    input  logic [10:0] cfg_write_data
);

    localparam int POS_W   = bmhq_pkg::POS_W;
    localparam int SHIFT_W = bmhq_pkg::SHIFT_W;
    localparam int PW      = $clog2(QUEUE_DEPTH + 1);
    localparam int NL      = PW;
    localparam int LW      = $clog2(NL);
    localparam int CMP_W   = (PW > 11) ? PW : 11;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TAIL,
        ST_RUN,
        ST_FIN
    } state_t;

    function automatic logic [LW-1:0] level_of(input logic [PW-1:0] p);
        logic [LW-1:0] lvl;
        lvl = '0;
        for (int i = 0; i < PW; i++)
        begin
            if (p[i])
            begin
                lvl = LW'(i);
            end
        end
        return lvl;
    endfunction

    state_t               state_reg, state_next;
    logic [PW-1:0]        fill_reg, fill_next;
    logic [PW-1:0]        high_reg, high_next;
    logic [10:0]          limit_reg;
    bmhq_pkg::entry_t     root_reg, root_next;
    logic [1:0]           res_status_reg, res_status_next;
    bmhq_pkg::entry_t     popped_reg, popped_next;
    logic [LW-1:0]        tail_lvl_reg, tail_lvl_next;

    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           out_status_reg, out_status_next;
    bmhq_pkg::entry_t     out_popped_reg, out_popped_next;
    logic                 out_top_valid_reg, out_top_valid_next;
    bmhq_pkg::entry_t     out_top_reg, out_top_next;
    logic [10:0]          out_count_reg, out_count_next;
    logic [10:0]          out_peak_reg, out_peak_next;

    logic                 accept;
    logic                 out_free;
    logic                 full;
    logic [CMP_W-1:0]     limit_w;
    logic [CMP_W-1:0]     depth_w;
    logic [CMP_W-1:0]     eff_limit;
    logic [PW-1:0]        fill_inc;
    bmhq_pkg::entry_t     new_item;
    bmhq_pkg::entry_t     tail_item;

    bmhq_pkg::link_t      ctrl_link;
    bmhq_pkg::tail_req_t  tail_req;
    logic [POS_W-1:0]     fill_bc;
    bmhq_pkg::link_t      lnk [1:NL];
    bmhq_pkg::up_t        up [1:NL];
    bmhq_pkg::entry_t     tail_entry [1:NL-1];
    logic [NL-1:1]        done_vec;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign limit_w   = CMP_W'(limit_reg);
    assign depth_w   = CMP_W'(QUEUE_DEPTH);
    assign eff_limit = (limit_w > depth_w) ? depth_w : limit_w;
    assign full      = (CMP_W'(fill_reg) >= eff_limit);
    assign fill_inc  = fill_reg + 1'b1;
    assign new_item  = '{key: push_key, node: push_node};
    assign tail_item = tail_entry[tail_lvl_reg];
    assign fill_bc   = POS_W'(fill_reg);

    assign lnk[1]  = ctrl_link;
    assign up[NL]  = '0;

    for (genvar g = 1; g < NL; g++)
    begin : g_level
        bmhq_level #(
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .LEVEL       (g)
        ) u_level (
            .clk        (clk),
            .rst_n      (rst_n),
            .fill       (fill_bc),
            .tail_req   (tail_req),
            .link_in    (lnk[g]),
            .link_out   (lnk[g+1]),
            .up_in      (up[g+1]),
            .up_out     (up[g]),
            .tail_entry (tail_entry[g]),
            .done       (done_vec[g])
        );
    end

    always_comb
    begin
        state_next         = state_reg;
        fill_next          = fill_reg;
        high_next          = high_reg;
        root_next          = root_reg;
        res_status_next    = res_status_reg;
        popped_next        = popped_reg;
        tail_lvl_next      = tail_lvl_reg;
        out_valid_next     = out_valid_reg && out_stall;
        out_status_next    = out_status_reg;
        out_popped_next    = out_popped_reg;
        out_top_valid_next = out_top_valid_reg;
        out_top_next       = out_top_reg;
        out_count_next     = out_count_reg;
        out_peak_next      = out_peak_reg;
        ctrl_link          = '0;
        tail_req           = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = bmhq_pkg::STATUS_OK;
                    popped_next     = '0;
                    state_next      = ST_FIN;
                    case (command)
                        bmhq_pkg::CMD_PUSH:
                        begin
                            if (full)
                            begin
                                res_status_next = bmhq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                fill_next = fill_inc;
                                if (fill_inc > high_reg)
                                begin
                                    high_next = fill_inc;
                                end
                                if (fill_reg == '0)
                                begin
                                    root_next = new_item;
                                end
                                else
                                begin
                                    // insert top-down along the path to the new leaf
                                    state_next      = ST_RUN;
                                    ctrl_link.valid = 1'b1;
                                    ctrl_link.op    = bmhq_pkg::OP_PUSH;
                                    ctrl_link.pos   = POS_W'(fill_inc);
                                    ctrl_link.shift = SHIFT_W'(level_of(fill_inc) - 1'b1);
                                    if (bmhq_pkg::ranks_before(new_item, root_reg))
                                    begin
                                        root_next      = new_item;
                                        ctrl_link.item = root_reg;
                                    end
                                    else
                                    begin
                                        ctrl_link.item = new_item;
                                    end
                                end
                            end
                        end
                        bmhq_pkg::CMD_POP:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_status_next = bmhq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                popped_next = root_reg;
                                fill_next   = fill_reg - 1'b1;
                                if (fill_reg != PW'(1))
                                begin
                                    tail_req.en   = 1'b1;
                                    tail_req.pos  = POS_W'(fill_reg);
                                    tail_lvl_next = level_of(fill_reg);
                                    state_next    = ST_TAIL;
                                end
                            end
                        end
                        bmhq_pkg::CMD_CLEAR:
                        begin
                            fill_next = '0;
                            high_next = '0;
                        end
                        bmhq_pkg::CMD_NOP:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_TAIL:
            begin
                if (fill_reg >= PW'(2))
                begin
                    ctrl_link.valid = 1'b1;
                    ctrl_link.op    = bmhq_pkg::OP_POP;
                    ctrl_link.pos   = POS_W'(1);
                    ctrl_link.item  = tail_item;
                    state_next      = ST_RUN;
                end
                else
                begin
                    root_next  = tail_item;
                    state_next = ST_FIN;
                end
            end
            ST_RUN:
            begin
                if (up[1].we)
                begin
                    root_next = up[1].item;
                end
                if (|done_vec)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_status_next    = res_status_reg;
                    out_popped_next    = popped_reg;
                    out_top_valid_next = (fill_reg != '0);
                    out_top_next       = (fill_reg != '0) ? root_reg : '0;
                    out_count_next     = 11'(fill_reg);
                    out_peak_next      = 11'(high_reg);
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            out_valid_reg     <= 1'b0;
            out_status_reg    <= '0;
            out_popped_reg    <= '0;
            out_top_valid_reg <= 1'b0;
            out_top_reg       <= '0;
            out_count_reg     <= '0;
            out_peak_reg      <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            out_valid_reg     <= out_valid_next;
            out_status_reg    <= out_status_next;
            out_popped_reg    <= out_popped_next;
            out_top_valid_reg <= out_top_valid_next;
            out_top_reg       <= out_top_next;
            out_count_reg     <= out_count_next;
            out_peak_reg      <= out_peak_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            high_reg  <= '0;
            limit_reg <= 11'd1024;
        end
        else
        begin
            fill_reg <= fill_next;
            high_reg <= high_next;
            if (cfg_write_en)
            begin
                limit_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        root_reg       <= root_next;
        res_status_reg <= res_status_next;
        popped_reg     <= popped_next;
        tail_lvl_reg   <= tail_lvl_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign popped_key  = out_popped_reg.key;
    assign popped_node = out_popped_reg.node;
    assign top_valid   = out_top_valid_reg;
    assign top_key     = out_top_reg.key;
    assign top_node    = out_top_reg.node;
    assign entry_count = out_count_reg;
    assign peak_count  = out_peak_reg;

    `ASSERT_IMPLY(a_no_token_past_last_level, clk, rst_n, 1'b1, !lnk[NL].valid)
    `ASSERT_IMPLY(a_fill_within_depth, clk, rst_n, 1'b1, fill_reg <= PW'(QUEUE_DEPTH))
    `ASSERT_IMPLY(a_peak_covers_fill, clk, rst_n, 1'b1, high_reg >= fill_reg)
    `ASSERT_IMPLY(a_single_level_done, clk, rst_n, |done_vec,
                  $onehot(done_vec) && (state_reg == ST_RUN))
    `ASSERT_NEXT(a_tail_then_walk, clk, rst_n, state_reg == ST_TAIL,
                 (state_reg == ST_RUN) || (state_reg == ST_FIN))

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int HEAP_DEPTH  = 1024;
    localparam int CLK_PERIOD  = 8;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] key;
        logic [31:0] node;
    } heap_op_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] popped_key;
        logic [31:0] popped_node;
        logic        top_valid;
        logic [31:0] top_key;
        logic [31:0] top_node;
        logic [10:0] entry_count;
        logic [10:0] peak_count;
    } heap_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  command = bmhq_pkg::CMD_NOP;
    logic [31:0] push_key = '0;
    logic [31:0] push_node = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [31:0] popped_key;
    logic [31:0] popped_node;
    logic        top_valid;
    logic [31:0] top_key;
    logic [31:0] top_node;
    logic [10:0] entry_count;
    logic [10:0] peak_count;
    logic        cfg_write_en = 1'b0;
    logic [10:0] cfg_write_data = '0;

    bmhq_pkg::entry_t heap_model [HEAP_DEPTH];
    int unsigned  fill_model = 0;
    int unsigned  peak_model = 0;
    int unsigned  limit_model = 1024;

    heap_op_t     pending_ops [$];
    heap_result_t awaited_results [$];
    heap_op_t     next_op;
    heap_result_t accepted_result;
    heap_result_t want;

    int unsigned  error_count = 0;
    int unsigned  cycle_count = 0;
    int unsigned  burst_left = 0;
    int unsigned  gap_left = 0;
    int unsigned  stall_mode = 0;
    int unsigned  mode_left = 0;

    binary_min_heap_queue #(
        .QUEUE_DEPTH(HEAP_DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .push_key      (push_key),
        .push_node     (push_node),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .popped_key    (popped_key),
        .popped_node   (popped_node),
        .top_valid     (top_valid),
        .top_key       (top_key),
        .top_node      (top_node),
        .entry_count   (entry_count),
        .peak_count    (peak_count),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic report_error(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("%0t: %s", $time, msg);
        error_count++;
    endtask

    // packed entry compares key first, node breaks ties
    task automatic heap_apply(input heap_op_t op, output heap_result_t r);
        int unsigned cap;
        int unsigned pos;
        int unsigned up;
        int unsigned lc;
        int unsigned c;
        bmhq_pkg::entry_t moving;
        r = '0;
        r.status = bmhq_pkg::STATUS_OK;
        cap = (limit_model > HEAP_DEPTH) ? HEAP_DEPTH : limit_model;
        case (op.command)
            bmhq_pkg::CMD_PUSH:
            begin
                if (fill_model >= cap)
                    r.status = bmhq_pkg::STATUS_FULL;
                else
                begin
                    moving.key = op.key;
                    moving.node = op.node;
                    pos = fill_model;
                    fill_model++;
                    if (fill_model > peak_model)
                        peak_model = fill_model;
                    while (pos > 0)
                    begin
                        up = (pos - 1) / 2;
                        if (!(moving < heap_model[up]))
                            break;
                        heap_model[pos] = heap_model[up];
                        pos = up;
                    end
                    heap_model[pos] = moving;
                end
            end
            bmhq_pkg::CMD_POP:
            begin
                if (fill_model == 0)
                    r.status = bmhq_pkg::STATUS_EMPTY;
                else
                begin
                    r.popped_key = heap_model[0].key;
                    r.popped_node = heap_model[0].node;
                    fill_model--;
                    if (fill_model > 0)
                    begin
                        moving = heap_model[fill_model];
                        pos = 0;
                        while (1'b1)
                        begin
                            lc = 2 * pos + 1;
                            if (lc >= fill_model)
                                break;
                            c = lc;
                            if (lc + 1 < fill_model && heap_model[lc + 1] < heap_model[lc])
                                c = lc + 1;
                            if (!(heap_model[c] < moving))
                                break;
                            heap_model[pos] = heap_model[c];
                            pos = c;
                        end
                        heap_model[pos] = moving;
                    end
                end
            end
            bmhq_pkg::CMD_CLEAR:
            begin
                fill_model = 0;
                peak_model = 0;
            end
            default:
            begin
            end
        endcase
        if (fill_model > 0)
        begin
            r.top_valid = 1'b1;
            r.top_key = heap_model[0].key;
            r.top_node = heap_model[0].node;
        end
        r.entry_count = fill_model[10:0];
        r.peak_count = peak_model[10:0];
    endtask

    function automatic logic [31:0] random_key();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 7);
            1: return $urandom_range(0, 255) << 8;
            2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] random_node();
        return $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom;
    endfunction

    function automatic heap_op_t random_op(input int unsigned push_weight);
        heap_op_t    op;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        op.key = random_key();
        op.node = random_node();
        if (roll < 2)
            op.command = bmhq_pkg::CMD_CLEAR;
        else if (roll < 5)
            op.command = bmhq_pkg::CMD_NOP;
        else if (roll < 5 + push_weight)
            op.command = bmhq_pkg::CMD_PUSH;
        else
            op.command = bmhq_pkg::CMD_POP;
        return op;
    endfunction

    function automatic void queue_op(input logic [1:0] cmd, input logic [31:0] key,
                                     input logic [31:0] node);
        pending_ops.push_back(heap_op_t'{cmd, key, node});
    endfunction

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_ops.size() != 0 || in_valid || awaited_results.size() != 0);
    endtask

    task automatic write_limit(input logic [10:0] value);
        wait_idle();
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        limit_model = 32'(value);
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // sender: bursts of transfers with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                heap_apply({command, push_key, push_node}, accepted_result);
                awaited_results.push_back(accepted_result);
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_ops.size() > 0)
                begin
                    next_op = pending_ops.pop_front();
                    in_valid <= 1'b1;
                    command <= next_op.command;
                    push_key <= next_op.key;
                    push_node <= next_op.node;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: check each result transfer, stall in changing modes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_mode <= 0;
            mode_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                    report_error("result transfer with nothing pending");
                else
                begin
                    want = awaited_results.pop_front();
                    if (status !== want.status)
                        report_error($sformatf("status %0d, expected %0d",
                                               status, want.status));
                    if (popped_key !== want.popped_key)
                        report_error($sformatf("popped_key %h, expected %h",
                                               popped_key, want.popped_key));
                    if (popped_node !== want.popped_node)
                        report_error($sformatf("popped_node %h, expected %h",
                                               popped_node, want.popped_node));
                    if (top_valid !== want.top_valid)
                        report_error($sformatf("top_valid %b, expected %b",
                                               top_valid, want.top_valid));
                    if (top_key !== want.top_key)
                        report_error($sformatf("top_key %h, expected %h",
                                               top_key, want.top_key));
                    if (top_node !== want.top_node)
                        report_error($sformatf("top_node %h, expected %h",
                                               top_node, want.top_node));
                    if (entry_count !== want.entry_count)
                        report_error($sformatf("entry_count %0d, expected %0d",
                                               entry_count, want.entry_count));
                    if (peak_count !== want.peak_count)
                        report_error($sformatf("peak_count %0d, expected %0d",
                                               peak_count, want.peak_count));
                end
            end
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(40, 300);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 2) == 0);
                default: out_stall <= (cycle_count % 16) < 6;
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin
        int unsigned p;
        int unsigned n;
        int unsigned weight;
        logic [10:0] lim;
        int unsigned phase_limits [10];
        phase_limits = '{1, 3, 2, 1025, 0, 7, 16, 1, 31, 1024};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty queue, ties, key extremes, clear with entries left
        queue_op(bmhq_pkg::CMD_POP, 32'h0, 32'h0);
        queue_op(bmhq_pkg::CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_op(bmhq_pkg::CMD_PUSH, 32'h0000_0500, 32'd7);
        queue_op(bmhq_pkg::CMD_PUSH, 32'h0000_0500, 32'd3);
        queue_op(bmhq_pkg::CMD_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_op(bmhq_pkg::CMD_PUSH, 32'h0, 32'hFFFF_FFFF);
        queue_op(bmhq_pkg::CMD_PUSH, 32'h0, 32'h0);
        queue_op(bmhq_pkg::CMD_PUSH, 32'h0000_0500, 32'd3);
        queue_op(bmhq_pkg::CMD_NOP, 32'h0, 32'h0);
        queue_op(bmhq_pkg::CMD_POP, 32'h0, 32'h0);
        queue_op(bmhq_pkg::CMD_POP, 32'h0, 32'h0);
        queue_op(bmhq_pkg::CMD_POP, 32'h0, 32'h0);
        queue_op(bmhq_pkg::CMD_POP, 32'h0, 32'h0);
        queue_op(bmhq_pkg::CMD_CLEAR, 32'h0, 32'h0);
        queue_op(bmhq_pkg::CMD_POP, 32'h0, 32'h0);

        // zero limit: every push full
        write_limit(11'd0);
        queue_op(bmhq_pkg::CMD_PUSH, 32'h1, 32'h1);
        queue_op(bmhq_pkg::CMD_POP, 32'h0, 32'h0);

        write_limit(11'd1);
        queue_op(bmhq_pkg::CMD_PUSH, 32'h1, 32'h1);
        queue_op(bmhq_pkg::CMD_PUSH, 32'h2, 32'h2);
        queue_op(bmhq_pkg::CMD_POP, 32'h0, 32'h0);
        queue_op(bmhq_pkg::CMD_POP, 32'h0, 32'h0);

        // limit above depth: fill to the depth, then drain part of it
        write_limit(11'h7FF);
        for (n = 0; n < HEAP_DEPTH + 3; n++)
            queue_op(bmhq_pkg::CMD_PUSH, random_key(), random_node());
        for (n = 0; n < 16; n++)
            queue_op(bmhq_pkg::CMD_POP, random_key(), random_node());
        for (n = 0; n < 16; n++)
            pending_ops.push_back(random_op(50));
        queue_op(bmhq_pkg::CMD_CLEAR, 32'h0, 32'h0);

        for (p = 0; p < 10; p++)
        begin
            lim = (p == 5 || p == 8) ? 11'($urandom_range(4, 40)) : 11'(phase_limits[p]);
            weight = (p % 3 == 0) ? 70 : ((p % 3 == 1) ? 30 : 50);
            write_limit(lim);
            for (n = 0; n < 5; n++)
                pending_ops.push_back(random_op(weight));
        end

        wait_idle();
        repeat (16) @(posedge clk);
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/bmhq_pkg.sv
sv/bmhq_level.sv
sv/binary_min_heap_queue.sv
verif/testbench.sv
